### src/ssrp_pkg.sv
// Package for the stepper speed ramp profile generator.
// Holds widths, register indexes, phase codes and datapath command types.
`default_nettype none
package ssrp_pkg;
    localparam int SPEED_WIDTH_DEF = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PHASE_W = 3;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 72;
    localparam int STEP_PULSES = 15360000;
    localparam int UNIT_SCALE = 10000;

    localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUAL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MICRO     = 3'd7;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ACCEL  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CRUISE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DECEL  = 3'd4;

    // datapath commands from the controller
    typedef struct packed {
        logic load;      // capture item and registers
        logic div_start; // start 15360000 / divisor
        logic mul_start; // start multiply (operand select below)
        logic mul_sel;   // 0 jog target, 1 distance
        logic tick;      // apply the tick update
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic need_dist; // positioning tick enters the start phase
    } dp_stat_t;
endpackage
`default_nettype wire

### src/ssrp_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Divides the fixed step pulse count by the microstep setting; uses ssrp_pkg.
`default_nettype none
module ssrp_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [15:0] divisor,
    output logic [23:0]      quotient,
    output logic             done
);
    logic [23:0] quot_reg, quot_next;
    logic [16:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [15:0] dv;
    logic [16:0] trial;
    logic [23:0] num;

    assign num = 24'(ssrp_pkg::STEP_PULSES);
    assign dv = (divisor == 16'd0) ? 16'd1 : divisor;
    assign trial = {rem_reg[15:0], num[cnt_reg]};

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quot_next = '0;
            rem_next  = '0;
            cnt_next  = 5'd23;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dv}) begin
                rem_next = trial - {1'b0, dv};
                quot_next = {quot_reg[22:0], 1'b1};
            end else begin
                rem_next = trial;
                quot_next = {quot_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quotient = quot_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

### src/ssrp_datapath.sv
// Speed ramp datapath: configuration registers, motion state, shift-add
// multiplier and tick update. Uses ssrp_pkg and ssrp_divider.
`default_nettype none
module ssrp_datapath #(
    parameter int SPEED_WIDTH = ssrp_pkg::SPEED_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [ssrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ssrp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [ssrp_pkg::IN_DATA_W-1:0]      in_data,
    input  wire ssrp_pkg::dp_cmd_t                   cmd,
    output ssrp_pkg::dp_stat_t                       stat,
    output logic [ssrp_pkg::OUT_DATA_W-1:0]          out_data
);
    localparam int W = SPEED_WIDTH;

    logic        run_mode_reg, dual_reg;
    logic [15:0] start_reg, accel_reg, coef_reg, base_reg, micro_reg;
    logic [13:0] dlow_reg;

    logic [W-1:0] speed_reg, speed_next, rem_reg, rem_next;
    logic [W-1:0] half_reg, half_next, adist_reg, adist_next;
    logic         dneg_reg, dneg_next, ppul_reg, pdir_reg;
    logic [2:0]   phase_reg, phase_next;

    logic         pu_reg, dr_reg;
    logic [15:0]  idx_reg;

    // shift-add multiplier, one bit per cycle, W-bit wrapping product
    logic [W-1:0] macc_reg, macc_next, mcand_reg, mcand_next;
    logic [31:0]  mplier_reg, mplier_next;
    logic [5:0]   mcnt_reg, mcnt_next;
    logic         mbusy_reg, mdone_reg, mdone_next, mbusy_next;

    logic [23:0]  quot;
    logic         div_done;
    logic [31:0]  units;

    ssrp_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .divisor(micro_reg), .quotient(quot), .done(div_done)
    );

    assign units = 32'(base_reg) * 32'(ssrp_pkg::UNIT_SCALE) + 32'(dlow_reg);

    always_comb begin
        macc_next = macc_reg; mcand_next = mcand_reg; mplier_next = mplier_reg;
        mcnt_next = mcnt_reg; mbusy_next = mbusy_reg; mdone_next = 1'b0;
        if (cmd.mul_start) begin
            macc_next = '0;
            mcnt_next = 6'd32;
            mbusy_next = 1'b1;
            if (cmd.mul_sel) begin
                mcand_next = W'({8'd0, quot});
                mplier_next = units;
            end else begin
                mcand_next = W'({12'd0, coef_reg, 4'd0});
                mplier_next = {16'd0, idx_reg};
            end
        end else if (mbusy_reg) begin
            if (mplier_reg[0]) macc_next = macc_reg + mcand_reg;
            mcand_next = {mcand_reg[W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[31:1]};
            mcnt_next = mcnt_reg - 6'd1;
            if (mcnt_reg == 6'd1) begin
                mbusy_next = 1'b0;
                mdone_next = 1'b1;
            end
        end
    end

    logic         edge_p, edge_d, zero_spd, active;
    logic [W-1:0] vmax, star, target, sp_a, sp_b, rem_tmp, vel;

    assign vmax = W'({12'd0, coef_reg, 4'd0});
    assign star = W'({12'd0, start_reg, 4'd0});
    assign target = W'({12'd0, base_reg, 4'd0}) + macc_reg;
    assign zero_spd = (speed_reg == '0);
    assign edge_p = !ppul_reg && pu_reg && zero_spd;
    assign edge_d = !pdir_reg && dr_reg && zero_spd;
    assign active = dual_reg ? (pu_reg | dr_reg) : pu_reg;

    always_comb begin
        speed_next = speed_reg; rem_next = rem_reg; half_next = half_reg;
        adist_next = adist_reg; dneg_next = dneg_reg; phase_next = phase_reg;
        sp_a = '0; sp_b = '0; rem_tmp = '0;
        if (!run_mode_reg) begin
            if (!active) begin
                sp_a = speed_reg - W'(accel_reg);
                speed_next = ($signed(sp_a) <= $signed(star)) ? '0 : sp_a;
            end else begin
                dneg_next = dr_reg;
                if ($signed(target) < $signed(speed_reg))
                    speed_next = speed_reg - W'(accel_reg);
                else if ($signed(speed_reg) < $signed(target))
                    speed_next = speed_reg + W'(accel_reg);
            end
        end else begin
            if (edge_p) begin
                phase_next = ssrp_pkg::PH_START; dneg_next = 1'b0;
            end else if (edge_d) begin
                phase_next = ssrp_pkg::PH_START; dneg_next = 1'b1;
            end
            rem_tmp = rem_reg;
            if (phase_next == ssrp_pkg::PH_START) begin
                rem_tmp = macc_reg;
                half_next = {macc_reg[W-1], macc_reg[W-1:1]};
                adist_next = '0;
                phase_next = ssrp_pkg::PH_ACCEL;
            end else if (phase_next == ssrp_pkg::PH_ACCEL) begin
                if ($signed(speed_reg) < $signed(vmax) &&
                    $signed(adist_reg) < $signed(half_reg)) begin
                    sp_a = speed_reg + W'(accel_reg);
                    speed_next = sp_a;
                    adist_next = adist_reg + sp_a;
                end else begin
                    phase_next = ssrp_pkg::PH_CRUISE;
                end
            end else if (phase_next == ssrp_pkg::PH_CRUISE &&
                         $signed(rem_reg) <= $signed(adist_reg)) begin
                phase_next = ssrp_pkg::PH_DECEL;
            end else if (phase_next == ssrp_pkg::PH_DECEL) begin
                sp_b = ($signed(star) < $signed(speed_reg)) ?
                       speed_reg - W'(accel_reg) : speed_reg;
                if ($signed(rem_reg) <= $signed(sp_b)) sp_b = rem_reg;
                if ($signed(rem_reg) <= 0) begin
                    phase_next = ssrp_pkg::PH_IDLE;
                    sp_b = '0;
                end
                speed_next = sp_b;
            end
            rem_next = rem_tmp - speed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_mode_reg <= 1'b0; dual_reg <= 1'b0; start_reg <= '0;
            accel_reg <= 16'd1; coef_reg <= '0; base_reg <= '0;
            dlow_reg <= '0; micro_reg <= 16'd1;
            speed_reg <= '0; rem_reg <= '0; half_reg <= '0; adist_reg <= '0;
            dneg_reg <= 1'b0; phase_reg <= ssrp_pkg::PH_IDLE;
            ppul_reg <= 1'b0; pdir_reg <= 1'b0;
            mbusy_reg <= 1'b0; mdone_reg <= 1'b0; mcnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    ssrp_pkg::REG_RUN_MODE:  run_mode_reg <= cfg_data[0];
                    ssrp_pkg::REG_DUAL:      dual_reg <= cfg_data[0];
                    ssrp_pkg::REG_START:     start_reg <= cfg_data;
                    ssrp_pkg::REG_ACCEL:     accel_reg <= cfg_data;
                    ssrp_pkg::REG_COEF:      coef_reg <= cfg_data;
                    ssrp_pkg::REG_BASE_HIGH: base_reg <= cfg_data;
                    ssrp_pkg::REG_DIST_LOW:  dlow_reg <= cfg_data[13:0];
                    ssrp_pkg::REG_MICRO:     micro_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.tick) begin
                speed_reg <= speed_next; rem_reg <= rem_next;
                half_reg <= half_next; adist_reg <= adist_next;
                dneg_reg <= dneg_next; phase_reg <= phase_next;
                ppul_reg <= pu_reg; pdir_reg <= dr_reg;
            end
            mbusy_reg <= mbusy_next; mdone_reg <= mdone_next; mcnt_reg <= mcnt_next;
        end
        if (cmd.load) begin
            pu_reg <= in_data[0]; dr_reg <= in_data[1]; idx_reg <= in_data[17:2];
        end
        macc_reg <= macc_next; mcand_reg <= mcand_next; mplier_reg <= mplier_next;
    end

    assign stat.div_done = div_done;
    assign stat.mul_done = mdone_reg;
    assign stat.need_dist = run_mode_reg &&
        (edge_p || edge_d || phase_reg == ssrp_pkg::PH_START);

    assign vel = dneg_reg ? (W'(0) - speed_reg) : speed_reg;
    assign out_data = {5'd0, 32'($signed(rem_reg)), phase_reg, 32'($signed(vel))};
endmodule
`default_nettype wire

### src/ssrp_ctrl.sv
// Sequencer for one control tick: accept, divide (positioning start only) and multiply, update, emit.
// Drives ssrp_datapath commands; uses ssrp_pkg types.
`default_nettype none
module ssrp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire ssrp_pkg::dp_stat_t stat,
    output ssrp_pkg::dp_cmd_t      cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0, ST_DECIDE = 3'd1, ST_DIV = 3'd2,
                           ST_MUL = 3'd3, ST_TICK = 3'd4, ST_OUT = 3'd5;
    logic [2:0] state_reg, state_next;
    logic       sel_reg, sel_next;

    always_comb begin
        state_next = state_reg; sel_next = sel_reg; cmd = '0;
        s_ready = 1'b0; m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1; state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // distance needs divide then multiply; jog needs target product
                if (stat.need_dist) begin
                    cmd.div_start = 1'b1; sel_next = 1'b1; state_next = ST_DIV;
                end else begin
                    cmd.mul_start = 1'b1; sel_next = 1'b0; state_next = ST_MUL;
                end
                cmd.mul_sel = 1'b0;
            end
            ST_DIV: if (stat.div_done) begin
                cmd.mul_start = 1'b1; cmd.mul_sel = 1'b1; state_next = ST_MUL;
            end
            ST_MUL: if (stat.mul_done) state_next = ST_TICK;
            ST_TICK: begin
                cmd.tick = 1'b1; state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; sel_reg <= 1'b0;
        end else begin
            state_reg <= state_next; sel_reg <= sel_next;
        end
    end
endmodule
`default_nettype wire

### src/stepper_speed_ramp_profile.sv
// Top level of the stepper speed ramp profile generator.
// One result item per input item; s_ stream in, m_ stream out, cfg write port.
// Usage:
//   Write registers through cfg_we/cfg_index/cfg_data while idle.
//   Each s_axis item is one control tick (pulse, dir, speed index) and
//   yields one m_axis item (velocity, phase, remaining distance).
//   A jog tick runs the 32-step shift-add multiplier; a positioning start
//   tick runs the 24-step divider then the multiplier; the other
//   positioning ticks run as a jog tick.
//   Items are handled one at a time; s_axis_tready is high only while the
//   sequencer waits for an item.
//   Reset (aresetn low, synchronous) clears all motion state and returns
//   registers to defaults. A stalled receiver holds the result item and
//   the block takes no new item until it is taken.
`default_nettype none
module stepper_speed_ramp_profile #(
    parameter int SPEED_WIDTH = ssrp_pkg::SPEED_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // pulse_level, dir_level, speed_index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata   // velocity, phase, remaining_distance
);
    ssrp_pkg::dp_cmd_t  cmd;
    ssrp_pkg::dp_stat_t stat;

    ssrp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .stat(stat), .cmd(cmd)
    );

    ssrp_datapath #(.SPEED_WIDTH(SPEED_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_data(s_axis_tdata), .cmd(cmd), .stat(stat), .out_data(m_axis_tdata)
    );
endmodule
`default_nettype wire

### bench/ssrp_scoreboard.sv
// Scoreboard for the stepper speed ramp profile generator bench.
// Predicts each result item from the input item and the register values.
// Depends on ssrp_pkg for the register indexes and phase codes.

typedef struct packed {
    logic [31:0] velocity;
    logic [2:0]  phase;
    logic [31:0] remaining;
} ramp_result_t;

class ramp_scoreboard;
    // register copy
    logic        run_mode, dual_mode;
    logic [15:0] start_speed, accel_step, speed_coef, base_high, micro_div;
    logic [13:0] dist_low;
    // motion state copy
    logic [31:0] speed, remaining, half_dist, accel_dist;
    logic        dir_neg, prev_pulse, prev_dir;
    logic [2:0]  move_phase;
    ramp_result_t expected_q[$];
    int          fails;
    int          seen;

    function new();
        fails = 0;
        seen = 0;
        run_mode = 0; dual_mode = 0; start_speed = 0; accel_step = 1;
        speed_coef = 0; base_high = 0; dist_low = 0; micro_div = 1;
        speed = 0; remaining = 0; half_dist = 0; accel_dist = 0;
        dir_neg = 0; prev_pulse = 0; prev_dir = 0; move_phase = ssrp_pkg::PH_IDLE;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            ssrp_pkg::REG_RUN_MODE:  run_mode = val[0];
            ssrp_pkg::REG_DUAL:      dual_mode = val[0];
            ssrp_pkg::REG_START:     start_speed = val;
            ssrp_pkg::REG_ACCEL:     accel_step = val;
            ssrp_pkg::REG_COEF:      speed_coef = val;
            ssrp_pkg::REG_BASE_HIGH: base_high = val;
            ssrp_pkg::REG_DIST_LOW:  dist_low = val[13:0];
            ssrp_pkg::REG_MICRO:     micro_div = val;
            default: ;
        endcase
    endfunction

    function void jog_tick(logic pu, logic dr, logic [15:0] idx);
        logic [31:0] target, floor_spd, step;
        logic        active;
        step = {16'd0, accel_step};
        target = ({16'd0, base_high} << 4) + ({16'd0, speed_coef} << 4) * {16'd0, idx};
        floor_spd = {16'd0, start_speed} << 4;
        active = dual_mode ? (pu | dr) : pu;
        if (!active) begin
            speed = speed - step;
            if ($signed(speed) <= $signed(floor_spd)) speed = 0;
        end else begin
            dir_neg = dr;
            if ($signed(target) < $signed(speed)) speed = speed - step;
            else if ($signed(speed) < $signed(target)) speed = speed + step;
        end
    endfunction

    function void position_tick(logic pu, logic dr);
        logic [31:0] vmax, floor_spd, step, per, units, divisor;
        step = {16'd0, accel_step};
        vmax = {16'd0, speed_coef} << 4;
        floor_spd = {16'd0, start_speed} << 4;
        if (!prev_pulse && pu && speed == 0) begin
            move_phase = ssrp_pkg::PH_START;
            dir_neg = 0;
        end else if (!prev_dir && dr && speed == 0) begin
            move_phase = ssrp_pkg::PH_START;
            dir_neg = 1;
        end
        if (move_phase == ssrp_pkg::PH_START) begin
            // a zero divisor counts as one
            divisor = (micro_div == 0) ? 32'd1 : {16'd0, micro_div};
            per = ssrp_pkg::STEP_PULSES / divisor;
            units = {16'd0, base_high} * ssrp_pkg::UNIT_SCALE + {18'd0, dist_low};
            remaining = units * per;
            half_dist = $signed(remaining) >>> 1;
            accel_dist = 0;
            move_phase = ssrp_pkg::PH_ACCEL;
        end else if (move_phase == ssrp_pkg::PH_ACCEL) begin
            if ($signed(speed) < $signed(vmax) && $signed(accel_dist) < $signed(half_dist)) begin
                speed = speed + step;
                accel_dist = accel_dist + speed;
            end else begin
                move_phase = ssrp_pkg::PH_CRUISE;
            end
        end else if (move_phase == ssrp_pkg::PH_CRUISE &&
                     $signed(remaining) <= $signed(accel_dist)) begin
            move_phase = ssrp_pkg::PH_DECEL;
        end else if (move_phase == ssrp_pkg::PH_DECEL) begin
            if ($signed(floor_spd) < $signed(speed)) speed = speed - step;
            if ($signed(remaining) <= $signed(speed)) speed = remaining;
            if ($signed(remaining) <= 0) begin
                move_phase = ssrp_pkg::PH_IDLE;
                speed = 0;
            end
        end
        remaining = remaining - speed;
    endfunction

    // note an accepted input item and queue its result
    function void note_item(logic [23:0] d);
        ramp_result_t r;
        if (run_mode) position_tick(d[0], d[1]);
        else jog_tick(d[0], d[1], d[17:2]);
        r.velocity = dir_neg ? (32'd0 - speed) : speed;
        r.phase = move_phase;
        r.remaining = remaining;
        prev_pulse = d[0];
        prev_dir = d[1];
        expected_q.push_back(r);
    endfunction

    function void check_result(logic [71:0] d);
        ramp_result_t e;
        seen++;
        if (expected_q.size() == 0) begin
            $error("result item with nothing expected: %h", d);
            fails++;
            return;
        end
        e = expected_q.pop_front();
        if (d[31:0] !== e.velocity) begin
            $error("velocity expected %0d got %0d", $signed(e.velocity), $signed(d[31:0]));
            fails++;
        end
        if (d[34:32] !== e.phase) begin
            $error("phase expected %0d got %0d", e.phase, d[34:32]);
            fails++;
        end
        if (d[66:35] !== e.remaining) begin
            $error("remaining_distance expected %0d got %0d",
                   $signed(e.remaining), $signed(d[66:35]));
            fails++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

### bench/tb_stepper_speed_ramp_profile.sv
// Top-level bench for stepper_speed_ramp_profile: jog and positioning runs.
// Drives the item stream and register port, checks results via ramp_scoreboard.
// Depends on ssrp_pkg and bench/ssrp_scoreboard.sv.
module tb_stepper_speed_ramp_profile;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0; // pulse_level, dir_level, speed_index[15:0], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;      // velocity[31:0], phase[2:0], remaining_distance[31:0]

    ramp_scoreboard sb = new();
    bit  no_idle = 0;
    int  stall_left = 0;
    int  phases_run = 0;
    int  items_sent = 0;

    stepper_speed_ramp_profile DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 aclk = ~aclk;

    // result side: random stall per item
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
            stall_left = no_idle ? 0 : $urandom_range(0, 19);
        end
        if (stall_left > 0) begin
            m_axis_tready <= 0;
            stall_left--;
        end else begin
            m_axis_tready <= 1;
        end
    end

    task automatic send_tick(logic pu, logic dr, logic [15:0] idx);
        logic [23:0] d;
        int gap;
        d = {6'd0, idx, dr, pu};
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_item(d);
        items_sent++;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drain, then write all registers
    task automatic set_regs(logic rm, logic dual, logic [15:0] st, logic [15:0] acc,
                            logic [15:0] coef, logic [15:0] bh, logic [15:0] dl,
                            logic [15:0] mic);
        logic [15:0] vals[8];
        vals = '{{15'd0, rm}, {15'd0, dual}, st, acc, coef, bh, dl, mic};
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            @(posedge aclk);
            sb.write_reg(i[2:0], vals[i]);
        end
        cfg_we <= 0;
        @(posedge aclk);
        phases_run++;
        no_idle = ($urandom_range(0, 3) == 0);
    endtask

    task automatic jog_run(int n);
        logic [15:0] idx;
        for (int i = 0; i < n; i++) begin
            idx = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            send_tick($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), idx);
        end
    endtask

    // mostly quiet lines with the odd start edge, some noise
    task automatic move_run(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 39);
            if (r == 0) send_tick(1, 0, 16'($urandom));
            else if (r == 1) send_tick(0, 1, 16'($urandom));
            else if (r == 2) send_tick(1, 1, 16'($urandom));
            else send_tick(0, 0, 16'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // defaults: jog, zero target
        send_tick(1, 0, 16'hFFFF);
        send_tick(0, 1, 16'h0000);
        send_tick(0, 0, 16'h0000);
        // extremes in jog, target wraps
        set_regs(0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        send_tick(1, 1, 16'hFFFF);
        send_tick(0, 1, 16'hFFFF);
        send_tick(0, 1, 16'h8000);
        send_tick(0, 0, 16'h0001);
        send_tick(1, 0, 16'h0000);
        send_tick(0, 0, 16'h0000);
        // positioning: short moves, restart on edge and zero divisor
        set_regs(1, 0, 16'd2, 16'd40, 16'd20, 16'd0, 16'd3, 16'd0);
        send_tick(1, 0, 16'd0);
        for (int i = 0; i < 6; i++) send_tick(0, 0, 16'd0);
        send_tick(0, 1, 16'd0);
        send_tick(0, 0, 16'd0);
        send_tick(1, 1, 16'd0);
        set_regs(0, 0, 16'd0, 16'd100, 16'd3, 16'd10, 16'd0, 16'd1);
        jog_run(150);
        set_regs(0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1);
        jog_run(80);
        set_regs(1, 0, 16'd100, 16'd5000, 16'd4000, 16'd0, 16'd9999, 16'd60000);
        move_run(150);
        // out-of-range low part and largest high part wrap
        set_regs(1, 1, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h3FFF, 16'd0);
        move_run(80);
        set_regs(1, 0, 16'd2, 16'd7, 16'd2, 16'd0, 16'd3, 16'hFFFF);
        move_run(200);
        set_regs(0, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 50)), 16'($urandom),
                 16'($urandom_range(0, 200)), 16'($urandom), 16'($urandom), 16'($urandom));
        jog_run(150);
        if (s_axis_tvalid) s_axis_tvalid <= 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("covered %0d input items over %0d register settings, %0d results checked",
                 items_sent, phases_run, sb.seen);
        if (sb.fails == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule

### sim.f
src/ssrp_pkg.sv
src/ssrp_divider.sv
src/ssrp_datapath.sv
src/ssrp_ctrl.sv
src/stepper_speed_ramp_profile.sv
bench/ssrp_scoreboard.sv
bench/tb_stepper_speed_ramp_profile.sv
